/* hw/rtl/sws_pkg.sv */
package sws_pkg;

    localparam int POINTS_DEF = 64;

    localparam int IDX_W    = 6;
    localparam int DISP_W   = 24;
    localparam int RATIO_W  = 15;
    localparam int NPTS_W   = 7;
    localparam int MODE_W   = 2;
    localparam int TDATA_W  = 32;

    // laplacian, product and accumulator widths
    localparam int LAP_W    = DISP_W + 2;
    localparam int PROD_W   = LAP_W + RATIO_W + 1;
    localparam int ACC_W    = PROD_W + 1;

    localparam int HALF_SHIFT = 15;
    localparam int FULL_SHIFT = 14;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_COURANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS  = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RST = 15'd16384;
    localparam logic [NPTS_W-1:0]  NPTS_RST  = 7'd64;
    localparam logic [NPTS_W-1:0]  NPTS_MIN  = 7'd3;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd2;

    localparam logic signed [DISP_W-1:0] DISP_MAX = 24'sh7FFFFF;
    localparam logic signed [DISP_W-1:0] DISP_MIN = 24'sh800000;

    // read tag that travels alongside the row memory read data
    typedef struct packed {
        logic valid;
        logic half;
    } tag_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic adv;
        logic busy;
    } pipe_stat_t;

endpackage

/* hw/rtl/sws_ram.sv */
module sws_ram #(
    parameter int WIDTH = sws_pkg::DISP_W,
    parameter int DEPTH = sws_pkg::POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/sws_ctrl.sv */
module sws_ctrl #(
    parameter int POINTS = sws_pkg::POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sws_pkg::MODE_W-1:0]          in_mode,
    input  logic [sws_pkg::IDX_W-1:0]           in_idx,
    input  logic [sws_pkg::DISP_W-1:0]          in_disp,
    input  logic [$clog2(POINTS+1)-1:0]         n_eff,
    input  sws_pkg::pipe_stat_t                 stat,
    output logic                                rd_en,
    output logic [$clog2(POINTS)-1:0]           rd_addr,
    output sws_pkg::tag_t                       tag1,
    output logic [$clog2(POINTS+1)-1:0]         k1,
    output logic                                sel,
    output logic                                clr_we,
    output logic [$clog2(POINTS)-1:0]           clr_addr,
    output logic                                ld_we,
    output logic [$clog2(POINTS)-1:0]           ld_addr,
    output logic [sws_pkg::DISP_W-1:0]          ld_data
);

    localparam int AW = $clog2(POINTS);
    localparam int CW = $clog2(POINTS + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  k1_reg, k1_next;
    sws_pkg::tag_t  tag1_reg, tag1_next;
    logic           sel_reg, sel_next;
    logic           half_reg, half_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        k1_next    = k1_reg;
        tag1_next  = tag1_reg;
        sel_next   = sel_reg;
        half_next  = half_reg;
        if (stat.adv)
        begin
            tag1_next.valid = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                k_next = k_reg + CW'(1);
                if (k_reg == CW'(POINTS - 1))
                begin
                    state_next = ST_IDLE;
                    k_next     = '0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode) inside
                        sws_pkg::MODE_HALF, sws_pkg::MODE_FULL:
                        begin
                            half_next  = (in_mode == sws_pkg::MODE_HALF);
                            k_next     = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (stat.adv)
                begin
                    tag1_next.valid = 1'b1;
                    tag1_next.half  = half_reg;
                    k1_next         = k_reg;
                    k_next          = k_reg + CW'(1);
                    if (k_reg == CW'(POINTS))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy && !tag1_reg.valid)
                begin
                    state_next = ST_IDLE;
                    // rows rotate once the full step has landed
                    if (!half_reg)
                    begin
                        sel_next = !sel_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            k1_reg    <= '0;
            tag1_reg  <= '0;
            sel_reg   <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            k1_reg    <= k1_next;
            tag1_reg  <= tag1_next;
            sel_reg   <= sel_next;
            half_reg  <= half_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_SWEEP) && stat.adv;
    assign rd_addr  = k_reg[AW-1:0];
    assign tag1     = tag1_reg;
    assign k1       = k1_reg;
    assign sel      = sel_reg;
    assign clr_we   = (state_reg == ST_CLEAR);
    assign clr_addr = k_reg[AW-1:0];

    // loads land only on interior points
    assign ld_we   = in_valid && in_ready && (in_mode == sws_pkg::MODE_LOAD)
                     && (in_idx != '0) && ((32'(in_idx) + 32'd1) < 32'(n_eff));
    assign ld_addr = AW'(in_idx);
    assign ld_data = in_disp;

endmodule

/* hw/rtl/sws_datapath.sv */
module sws_datapath #(
    parameter int POINTS = sws_pkg::POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sws_pkg::tag_t                       tag1,
    input  logic [$clog2(POINTS+1)-1:0]         k1,
    input  logic [$clog2(POINTS+1)-1:0]         n_eff,
    input  logic [sws_pkg::RATIO_W-1:0]         ratio,
    input  logic signed [sws_pkg::DISP_W-1:0]   prev_rd,
    input  logic signed [sws_pkg::DISP_W-1:0]   cur_rd,
    output sws_pkg::pipe_stat_t                 stat,
    output logic                                wr_en,
    output logic                                wr_cur,
    output logic [$clog2(POINTS)-1:0]           wr_addr,
    output logic [sws_pkg::DISP_W-1:0]          wr_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sws_pkg::IDX_W-1:0]           out_idx,
    output logic [sws_pkg::DISP_W-1:0]          out_disp,
    output logic                                out_last
);

    localparam int AW     = $clog2(POINTS);
    localparam int DISP_W = sws_pkg::DISP_W;
    localparam int LAP_W  = sws_pkg::LAP_W;
    localparam int PROD_W = sws_pkg::PROD_W;
    localparam int ACC_W  = sws_pkg::ACC_W;
    localparam int HS     = sws_pkg::HALF_SHIFT;
    localparam int FS     = sws_pkg::FULL_SHIFT;

    logic adv;

    // stage 1: window over the source row
    logic signed [DISP_W-1:0] w1_reg, w2_reg, p1_reg;
    logic                     edge_pt;
    logic signed [DISP_W-1:0] src_m, oth_m;
    logic signed [LAP_W-1:0]  lap;
    logic signed [LAP_W-1:0]  base;
    logic signed [ACC_W-1:0]  base_ext;
    logic signed [ACC_W-1:0]  addend;
    logic                     pt_valid;

    // stage 2 and 3
    logic                     v2_reg, v3_reg;
    logic                     half2_reg, half3_reg;
    logic [AW-1:0]            i2_reg, i3_reg;
    logic signed [LAP_W-1:0]  lap2_reg;
    logic signed [ACC_W-1:0]  add2_reg, add3_reg;
    logic signed [PROD_W-1:0] prod3_reg;

    logic signed [ACC_W-1:0]  total;
    logic signed [ACC_W-1:0]  shifted;
    logic [DISP_W-1:0]        sat;
    logic                     interior;
    logic                     last;

    logic                     out_valid_reg;
    logic [sws_pkg::IDX_W-1:0] out_idx_reg;
    logic [DISP_W-1:0]        out_disp_reg;
    logic                     out_last_reg;

    assign adv = !out_valid_reg || out_ready;

    // fixed ends read as zero
    assign edge_pt  = (k1 == '0) || ((32'(k1) + 32'd1) >= 32'(n_eff));
    assign src_m    = edge_pt ? '0 : (tag1.half ? prev_rd : cur_rd);
    assign oth_m    = edge_pt ? '0 : prev_rd;
    assign pt_valid = tag1.valid && (k1 != '0);

    always_comb
    begin
        lap      = LAP_W'(w2_reg) + LAP_W'(src_m) - (LAP_W'(w1_reg) <<< 1);
        base     = tag1.half ? LAP_W'(w1_reg) : ((LAP_W'(w1_reg) <<< 1) - LAP_W'(p1_reg));
        base_ext = ACC_W'(base);
        // rounding bias sits below the shifted base
        if (tag1.half)
        begin
            addend = (base_ext <<< HS) | (ACC_W'(1) << (HS - 1));
        end
        else
        begin
            addend = (base_ext <<< FS) | (ACC_W'(1) << (FS - 1));
        end
    end

    always_comb
    begin
        total   = ACC_W'(prod3_reg) + add3_reg;
        shifted = half3_reg ? (total >>> HS) : (total >>> FS);
        if ((shifted[ACC_W-1:DISP_W-1] == '0) || (shifted[ACC_W-1:DISP_W-1] == '1))
        begin
            sat = shifted[DISP_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat = sws_pkg::DISP_MIN;
        end
        else
        begin
            sat = sws_pkg::DISP_MAX;
        end
        interior = (i3_reg != '0) && ((32'(i3_reg) + 32'd1) < 32'(n_eff));
        last     = ((32'(i3_reg) + 32'd2) == 32'(n_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg        <= pt_valid;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg && interior;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tag1.valid)
            begin
                w1_reg <= src_m;
                w2_reg <= w1_reg;
                p1_reg <= oth_m;
            end
            half2_reg    <= tag1.half;
            i2_reg       <= AW'(k1 - 1'b1);
            lap2_reg     <= lap;
            add2_reg     <= addend;
            half3_reg    <= half2_reg;
            i3_reg       <= i2_reg;
            prod3_reg    <= lap2_reg * $signed({1'b0, ratio});
            add3_reg     <= add2_reg;
            out_idx_reg  <= sws_pkg::IDX_W'(i3_reg);
            out_disp_reg <= sat;
            out_last_reg <= last;
        end
    end

    // full step rewrites the whole row, zero outside the interior
    assign wr_en   = adv && v3_reg && (interior || !half3_reg);
    assign wr_cur  = half3_reg;
    assign wr_addr = i3_reg;
    assign wr_data = interior ? sat : '0;

    assign stat.adv  = adv;
    assign stat.busy = v2_reg || v3_reg;

    assign out_valid = out_valid_reg;
    assign out_idx   = out_idx_reg;
    assign out_disp  = out_disp_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/string_wave_stencil_step_unit.sv */
// Leapfrog stencil engine for a vibrating string with fixed ends. Two row
// memories hold the previous and current displacements (signed Q3.20); a
// request with tuser 0 loads one interior point of the previous row, tuser 1
// forms the first half step into the current row, tuser 2 forms a full step
// and rotates the rows by swapping the roles of the two memories. Step
// requests stream one result per interior point, ascending, with tlast on
// the last one; results saturate. A load or an unused code leaves it idle.
// A step sweeps all POINTS entries of the rows at one point per cycle,
// while m_tready does not hold the output, through a four-stage read,
// multiply and write-back pipeline. After reset both rows are cleared,
// during which s_tready stays low. Configuration writes (index 0
// courant_ratio, 1 active_points) are taken at any time, but the user must
// send them only while no request is in flight; the block does not enforce it.
module string_wave_stencil_step_unit #(
    parameter int POINTS = sws_pkg::POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sws_pkg::TDATA_W-1:0]       s_tdata,   // point_index, displacement, pad
    input  logic [sws_pkg::MODE_W-1:0]        s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sws_pkg::TDATA_W-1:0]       m_tdata,   // point_index_res, new_displacement, pad
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW     = $clog2(POINTS);
    localparam int CW     = $clog2(POINTS + 1);
    localparam int DISP_W = sws_pkg::DISP_W;
    localparam int IDX_W  = sws_pkg::IDX_W;

    logic [sws_pkg::RATIO_W-1:0] ratio_reg;
    logic [sws_pkg::NPTS_W-1:0]  npts_reg;
    logic [CW-1:0]               n_eff;

    sws_pkg::pipe_stat_t stat;
    sws_pkg::tag_t       tag1;
    logic [CW-1:0]       k1;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                sel;
    logic                clr_we;
    logic [AW-1:0]       clr_addr;
    logic                ld_we;
    logic [AW-1:0]       ld_addr;
    logic [DISP_W-1:0]   ld_data;

    logic                dp_we;
    logic                dp_cur;
    logic [AW-1:0]       dp_addr;
    logic [DISP_W-1:0]   dp_data;
    logic                dp_mem1;

    logic [DISP_W-1:0]   rd0, rd1;
    logic                we0, we1;
    logic [AW-1:0]       waddr;
    logic [DISP_W-1:0]   wdata;

    logic [IDX_W-1:0]    out_idx;
    logic [DISP_W-1:0]   out_disp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= sws_pkg::RATIO_RST;
            npts_reg  <= sws_pkg::NPTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sws_pkg::CFG_COURANT: ratio_reg <= cfg_data[sws_pkg::RATIO_W-1:0];
                sws_pkg::CFG_POINTS:  npts_reg  <= cfg_data[sws_pkg::NPTS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (npts_reg < sws_pkg::NPTS_MIN)
        begin
            n_eff = CW'(3);
        end
        else if (32'(npts_reg) > 32'(POINTS))
        begin
            n_eff = CW'(POINTS);
        end
        else
        begin
            n_eff = CW'(npts_reg);
        end
    end

    sws_ctrl #(
        .POINTS(POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_idx   (s_tdata[IDX_W-1:0]),
        .in_disp  (s_tdata[IDX_W+DISP_W-1:IDX_W]),
        .n_eff    (n_eff),
        .stat     (stat),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .tag1     (tag1),
        .k1       (k1),
        .sel      (sel),
        .clr_we   (clr_we),
        .clr_addr (clr_addr),
        .ld_we    (ld_we),
        .ld_addr  (ld_addr),
        .ld_data  (ld_data)
    );

    // previous row lives in memory sel, current row in the other
    sws_datapath #(
        .POINTS(POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag1      (tag1),
        .k1        (k1),
        .n_eff     (n_eff),
        .ratio     (ratio_reg),
        .prev_rd   (sel ? rd1 : rd0),
        .cur_rd    (sel ? rd0 : rd1),
        .stat      (stat),
        .wr_en     (dp_we),
        .wr_cur    (dp_cur),
        .wr_addr   (dp_addr),
        .wr_data   (dp_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (out_idx),
        .out_disp  (out_disp),
        .out_last  (m_tlast)
    );

    assign dp_mem1 = dp_cur ^ sel;

    assign we0   = clr_we || (ld_we && !sel) || (dp_we && !dp_mem1);
    assign we1   = clr_we || (ld_we && sel) || (dp_we && dp_mem1);
    assign waddr = clr_we ? clr_addr : (ld_we ? ld_addr : dp_addr);
    assign wdata = clr_we ? '0 : (ld_we ? ld_data : dp_data);

    sws_ram #(
        .WIDTH(DISP_W),
        .DEPTH(POINTS)
    ) u_mem0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd0)
    );

    sws_ram #(
        .WIDTH(DISP_W),
        .DEPTH(POINTS)
    ) u_mem1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd1)
    );

    assign m_tdata = {(sws_pkg::TDATA_W - IDX_W - DISP_W)'(0), out_disp, out_idx};

    // fixed ends are never reported; this checks point 0
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[IDX_W-1:0] != '0))
        else $error("end point reported");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(stat.busy || tag1.valid))
        else $error("request accepted with step in flight");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({clr_we, ld_we, dp_we}) <= 1)
        else $error("row memory write collision");

endmodule

/* tb/sv/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 800000;
    localparam int HOLDOFF_AFTER  = 700;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = POINTS_DEF + 10;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 37;
    localparam int SCRIPT_LEN     = 29;

    typedef struct {
        logic [IDX_W-1:0]         point;
        logic signed [DISP_W-1:0] disp;
        logic                     last;
    } point_result_t;

    typedef struct packed {
        logic                     is_cfg;
        logic [RATIO_W-1:0]       ratio;
        logic [NPTS_W-1:0]        npts;
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         point;
        logic signed [DISP_W-1:0] disp;
        logic                     typed;
        logic signed [DISP_W-1:0] typed_disp;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic [MODE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // string state as the block should hold it
    logic signed [DISP_W-1:0] prev_row [POINTS_DEF];
    logic signed [DISP_W-1:0] cur_row [POINTS_DEF];
    logic [RATIO_W-1:0]       ratio_reg;
    logic [NPTS_W-1:0]        npts_reg;

    point_result_t pending_points [$];

    bit steady = 1'b0;
    bit holdoff_done = 1'b0;
    int holdoff_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int points_checked = 0;
    int loads_taken = 0;
    int steps_taken = 0;
    int ignored_taken = 0;
    int settings_used = 0;

    // directed requests; a typed value is what every point of that step must read
    script_row_t script [SCRIPT_LEN] = '{
        '{1'b0, '0, '0, MODE_HALF, 6'd0, 24'sd0, 1'b1, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd0, 24'sd123, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd63, DISP_MAX, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_UNUSED, 6'd5, -24'sd1, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b1, 24'sd0},
        '{1'b1, RATIO_RST, NPTS_MIN, MODE_LOAD, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd1, DISP_MIN, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd2, DISP_MAX, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_HALF, 6'd0, 24'sd0, 1'b1, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b1, DISP_MAX},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b1, 24'sd0},
        '{1'b1, 15'd0, NPTS_MIN, MODE_LOAD, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd1, 24'sd5, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_HALF, 6'd63, -24'sd1, 1'b0, 24'sd0},
        '{1'b1, RATIO_RST, NPTS_RST, MODE_LOAD, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd62, DISP_MAX, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd1, DISP_MIN, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd31, -24'sd1, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd40, 24'sh2AAAAA, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_HALF, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd21, DISP_MIN, 1'b0, 24'sd0},
        '{1'b1, 15'd1, 7'd4, MODE_LOAD, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd1, DISP_MAX, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd2, DISP_MIN, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_HALF, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_LOAD, 6'd3, DISP_MAX, 1'b0, 24'sd0},
        '{1'b0, '0, '0, MODE_FULL, 6'd0, 24'sd0, 1'b0, 24'sd0}
    };

    string_wave_stencil_step_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int points_in_use();
        if (npts_reg < NPTS_MIN)
            return 3;
        if (npts_reg > POINTS_DEF)
            return POINTS_DEF;
        return int'(npts_reg);
    endfunction

    // fixed ends read as zero whatever is stored
    function automatic longint row_point(bit from_cur, int i, int n);
        if (i <= 0 || i >= n - 1)
            return 0;
        if (from_cur)
            return longint'(cur_row[i]);
        return longint'(prev_row[i]);
    endfunction

    function automatic longint laplacian(bit from_cur, int i, int n);
        return row_point(from_cur, i - 1, n) + row_point(from_cur, i + 1, n)
            - 2 * row_point(from_cur, i, n);
    endfunction

    // round half up, arithmetic shift floors
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [DISP_W-1:0] saturate(longint v);
        if (v > longint'(DISP_MAX))
            return DISP_MAX;
        if (v < longint'(DISP_MIN))
            return DISP_MIN;
        return DISP_W'(v);
    endfunction

    function automatic void predict_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] point,
                                            logic signed [DISP_W-1:0] disp);
        logic signed [DISP_W-1:0] next_row [POINTS_DEF];
        point_result_t r;
        longint ratio;
        int n;
        n = points_in_use();
        ratio = ratio_reg;
        case (mode)
            MODE_LOAD:
            begin
                if (point > 0 && point < n - 1)
                begin
                    prev_row[point] = disp;
                    loads_taken++;
                end
                else
                    ignored_taken++;
                return;
            end
            MODE_HALF:
            begin
                for (int i = 1; i < n - 1; i++)
                    cur_row[i] = saturate(row_point(1'b0, i, n)
                        + round_shift(ratio * laplacian(1'b0, i, n), HALF_SHIFT));
            end
            MODE_FULL:
            begin
                foreach (next_row[i])
                    next_row[i] = '0;
                for (int i = 1; i < n - 1; i++)
                    next_row[i] = saturate(2 * row_point(1'b1, i, n) - row_point(1'b0, i, n)
                        + round_shift(ratio * laplacian(1'b1, i, n), FULL_SHIFT));
                prev_row = cur_row;
                cur_row = next_row;
            end
            default:
            begin
                ignored_taken++;
                return;
            end
        endcase
        steps_taken++;
        for (int i = 1; i < n - 1; i++)
        begin
            r.point = IDX_W'(i);
            r.disp = cur_row[i];
            r.last = (i == n - 2);
            pending_points.push_back(r);
        end
    endfunction

    function automatic void check_point(logic [TDATA_W-1:0] data, logic last);
        point_result_t want;
        logic [IDX_W-1:0] got_point;
        logic signed [DISP_W-1:0] got_disp;
        got_point = data[IDX_W-1:0];
        got_disp = data[IDX_W +: DISP_W];
        if (pending_points.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: point %0d value %0d last %0b",
                         got_point, got_disp, last);
            mismatches++;
            return;
        end
        want = pending_points.pop_front();
        if (got_point !== want.point || got_disp !== want.disp || last !== want.last)
        begin
            if (mismatches < 10)
                $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b (point/value/last)",
                         want.point, want.disp, want.last, got_point, got_disp, last);
            mismatches++;
        end
        points_checked++;
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] point,
                                input logic signed [DISP_W-1:0] disp, input bit typed = 1'b0,
                                input logic signed [DISP_W-1:0] typed_disp = '0);
        int first;
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W - IDX_W - DISP_W){1'b0}}, disp, point};
        s_tuser <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        first = pending_points.size();
        predict_request(mode, point, disp);
        if (typed)
            for (int k = first; k < pending_points.size(); k++)
                pending_points[k].disp = typed_disp;
    endtask

    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [RATIO_W-1:0] ratio, input logic [NPTS_W-1:0] npts);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COURANT;
        cfg_data <= CFG_DATA_W'(ratio);
        do
            @(posedge clk);
        while (!cfg_ready);
        ratio_reg = ratio;
        cfg_index <= CFG_POINTS;
        cfg_data <= CFG_DATA_W'(npts);
        do
            @(posedge clk);
        while (!cfg_ready);
        npts_reg = npts;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [DISP_W-1:0] random_disp();
        case ($urandom_range(0, 9))
            0: return DISP_MAX;
            1: return DISP_MIN;
            2: return DISP_W'(int'($urandom_range(0, 64)) - 32);
            default: return DISP_W'($urandom);
        endcase
    endfunction

    // requests the block drops: loads on an end or past it, unused code
    task automatic send_noise(input int n);
        if ($urandom_range(0, 1) == 0)
            send_request(MODE_UNUSED, IDX_W'($urandom), random_disp());
        else if ($urandom_range(0, 3) == 0)
            send_request(MODE_LOAD, '0, random_disp());
        else
            send_request(MODE_LOAD, IDX_W'($urandom_range(n - 1, POINTS_DEF - 1)), random_disp());
    endtask

    // loads, a half step, then a few full steps; sometimes the half step is skipped
    task automatic run_phase(input int target);
        int done;
        int n;
        int loads;
        int fulls;
        done = 0;
        n = points_in_use();
        while (done < target)
        begin
            loads = $urandom_range(1, (n - 2 < 8) ? n - 2 : 8);
            repeat (loads)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_noise(n);
                send_request(MODE_LOAD, IDX_W'($urandom_range(1, n - 2)), random_disp());
                done++;
            end
            if ($urandom_range(0, 99) < 80)
            begin
                send_request(MODE_HALF, IDX_W'($urandom), DISP_W'($urandom));
                done++;
            end
            fulls = $urandom_range(1, 4);
            repeat (fulls)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_noise(n);
                send_request(MODE_FULL, IDX_W'($urandom), DISP_W'($urandom));
                done++;
            end
        end
    endtask

    // result side: check, then random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_point(m_tdata, m_tlast);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else if (!holdoff_done && points_checked >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [RATIO_W-1:0] ratio;
        logic [NPTS_W-1:0] npts;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_COURANT;
        cfg_data = '0;
        foreach (prev_row[i])
        begin
            prev_row[i] = '0;
            cur_row[i] = '0;
        end
        ratio_reg = RATIO_RST;
        npts_reg = NPTS_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                wait_for_quiet();
                configure(script[k].ratio, script[k].npts);
            end
            else
                send_request(script[k].mode, script[k].point, script[k].disp,
                             script[k].typed, script[k].typed_disp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ratio = RATIO_RST;
                    npts = NPTS_RST;
                end
                1:
                begin
                    ratio = '0;
                    npts = NPTS_MIN;
                end
                3:
                begin
                    ratio = RATIO_RST;
                    npts = NPTS_W'($urandom_range(3, 10));
                end
                4:
                begin
                    ratio = RATIO_W'($urandom_range(0, 16384));
                    npts = NPTS_RST;
                end
                default:
                begin
                    ratio = RATIO_W'($urandom_range(0, 16384));
                    npts = NPTS_W'($urandom_range(3, 64));
                end
            endcase
            wait_for_quiet();
            configure(ratio, npts);
            steady = (p == 2);
            run_phase(PHASE_ITEMS);
            steady = 1'b0;
        end

        wait_for_quiet();
        $display("covered %0d loads, %0d steps and %0d dropped requests under %0d settings",
                 loads_taken, steps_taken, ignored_taken, settings_used);
        $display("checked %0d points in %0d cycles, %0d mismatches",
                 points_checked, cycle_count, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
